/* rtl/rsst_pkg.sv */
package rsst_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 12;
  localparam int TAG_W       = 5;
  localparam int PAYLOAD_W   = KEY_W + TAG_W;
  localparam int TDATA_W     = ((PAYLOAD_W + 7) / 8) * 8;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
  } rec_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS_RD,
    ST_PASS_CAP,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT_RD,
    ST_EMIT_CAP,
    ST_EMIT_WAIT
  } state_t;

  // read address source
  typedef enum logic [1:0] {
    RD_PASS,
    RD_PASS_NEXT,
    RD_SCAN_NEXT,
    RD_EMIT
  } rd_src_t;

  typedef struct packed {
    logic    store;       // write incoming record at count
    logic    drop;        // store full, flag overflow
    logic    start_sort;  // i <= 0
    logic    start_emit;  // k <= 0
    logic    cap_pass;    // cur/best <= record i, j <= i+1
    logic    scan_step;   // compare record j, j <= j+1
    logic    wr_best;     // mem[best_idx] <= cur
    logic    wr_pass;     // mem[i] <= best, i <= i+1
    logic    load_out;    // output register <= record k
    logic    next_emit;   // k <= k+1
    logic    clear;       // set finished
    rd_src_t rd_src;
  } cmd_t;

  typedef struct packed {
    logic full;       // store at capacity
    logic need_sort;  // more than one record once current beat lands
    logic scan_end;   // j is the last held record
    logic pass_end;   // no pass after the current one
    logic out_take;   // output beat taken
    logic emit_last;  // k is the last held record
  } status_t;

endpackage

/* rtl/rsst_ctrl.sv */
module rsst_ctrl
  import rsst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_valid,
  input  logic    s_last,
  output logic    s_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   in_fire;

  assign s_ready = (state == ST_LOAD);
  assign in_fire = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_fire && s_last) begin
          state_next = status.need_sort ? ST_PASS_RD : ST_EMIT_RD;
        end
      end
      ST_PASS_RD:  state_next = ST_PASS_CAP;
      ST_PASS_CAP: state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_end) begin
          state_next = ST_SWAP_A;
        end
      end
      ST_SWAP_A:   state_next = ST_SWAP_B;
      ST_SWAP_B:   state_next = status.pass_end ? ST_EMIT_RD : ST_PASS_RD;
      ST_EMIT_RD:  state_next = ST_EMIT_CAP;
      ST_EMIT_CAP: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (status.out_take) begin
          state_next = status.emit_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default:     state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_src = RD_EMIT;
    unique case (state)
      ST_LOAD: begin
        cmd.store      = in_fire && !status.full;
        cmd.drop       = in_fire && status.full;
        cmd.start_sort = in_fire && s_last;
        cmd.start_emit = in_fire && s_last;
      end
      ST_PASS_RD: begin
        cmd.rd_src = RD_PASS;
      end
      ST_PASS_CAP: begin
        cmd.cap_pass = 1'b1;
        cmd.rd_src   = RD_PASS_NEXT;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.rd_src    = RD_SCAN_NEXT;
      end
      ST_SWAP_A: begin
        cmd.wr_best = 1'b1;
      end
      ST_SWAP_B: begin
        cmd.wr_pass = 1'b1;
      end
      ST_EMIT_RD: begin
        cmd.rd_src = RD_EMIT;
      end
      ST_EMIT_CAP: begin
        cmd.load_out = 1'b1;
      end
      ST_EMIT_WAIT: begin
        cmd.next_emit = status.out_take;
        cmd.clear     = status.out_take && status.emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/rsst_datapath.sv */
module rsst_datapath
  import rsst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic [KEY_W-1:0] in_key,
  input  logic [TAG_W-1:0] in_tag,
  output logic [KEY_W-1:0] out_key,
  output logic [TAG_W-1:0] out_tag,
  output logic             out_last,
  output logic             out_ovf,
  output logic             out_valid,
  input  logic             out_ready
);

  rec_t mem [MAX_RECORDS];
  rec_t rd_data;

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [IDX_W-1:0] i_idx;
  logic [IDX_W-1:0] j_idx;
  logic [IDX_W-1:0] k_idx;
  logic [IDX_W-1:0] best_idx;
  rec_t             cur;
  rec_t             best;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_data;
  logic             full;
  logic [CNT_W-1:0] count_m1;

  assign full     = (count == CNT_W'(MAX_RECORDS));
  assign count_m1 = count - CNT_W'(1);

  always_comb begin
    case (cmd.rd_src)
      RD_PASS:      rd_addr = i_idx;
      RD_PASS_NEXT: rd_addr = i_idx + IDX_W'(1);
      RD_SCAN_NEXT: rd_addr = j_idx + IDX_W'(1);
      default:      rd_addr = k_idx;
    endcase
  end

  always_comb begin
    wr_en   = cmd.store || cmd.wr_best || cmd.wr_pass;
    wr_addr = count[IDX_W-1:0];
    wr_data = '{tag: in_tag, key: in_key};
    if (cmd.wr_best) begin
      wr_addr = best_idx;
      wr_data = cur;
    end else if (cmd.wr_pass) begin
      wr_addr = i_idx;
      wr_data = best;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // scan, pass and emit bookkeeping, output register load
  always_ff @(posedge clk) begin
    if (cmd.start_sort) begin
      i_idx <= '0;
    end else if (cmd.wr_pass) begin
      i_idx <= i_idx + IDX_W'(1);
    end
    if (cmd.cap_pass) begin
      cur      <= rd_data;
      best     <= rd_data;
      best_idx <= i_idx;
      j_idx    <= i_idx + IDX_W'(1);
    end else if (cmd.scan_step) begin
      if (rd_data.key < best.key) begin
        best     <= rd_data;
        best_idx <= j_idx;
      end
      j_idx <= j_idx + IDX_W'(1);
    end
    if (cmd.start_emit) begin
      k_idx <= '0;
    end else if (cmd.next_emit) begin
      k_idx <= k_idx + IDX_W'(1);
    end
    if (cmd.load_out) begin
      out_key  <= rd_data.key;
      out_tag  <= rd_data.tag;
      out_last <= (CNT_W'(k_idx) == count_m1);
      out_ovf  <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        if (cmd.store) begin
          count <= count + CNT_W'(1);
        end
        if (cmd.drop) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.full      = full;
    status.need_sort = (count != '0);
    status.scan_end  = (CNT_W'(j_idx) == count_m1);
    status.pass_end  = (CNT_W'(i_idx) + CNT_W'(2) >= count);
    status.out_take  = out_valid && out_ready;
    status.emit_last = (CNT_W'(k_idx) == count_m1);
  end

endmodule

/* rtl/record_selection_sort_by_time_top.sv */
// Record selection sorter by time key.
// Input stream (s_axis): one record per beat, tdata = {record_tag, time_key},
// tlast marks the final record of a set. Records beyond MAX_RECORDS are
// dropped and remembered as overflow.
// After the tlast beat the block stops taking beats (s_axis_tready low),
// selection-sorts the held records by ascending key (first strict minimum
// wins each pass) and then streams them on m_axis, tlast on the final one,
// tuser = overflow flag on every beat of that run.
// Loading keeps s_axis_tready high, so beats are taken back to back. Sorting
// makes one key compare per cycle against the record memory's single read
// port, plus read, capture and two swap writes per pass. Emission reads each
// record from memory, loads it into the output register and hands the beat
// off before the next record is read.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits. Reset (rst, synchronous) empties the set and clears the
// overflow flag; stored records need no clearing.
module record_selection_sort_by_time_top
  import rsst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // time_key[11:0], record_tag[16:12], zero pad
  input  logic               s_axis_tlast,   // last_item
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // sorted_key[11:0], sorted_tag[16:12], zero pad
  output logic               m_axis_tlast,   // last_out
  output logic [0:0]         m_axis_tuser    // overflow
);

  cmd_t             cmd;
  status_t          status;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic             out_ovf;

  // sequencer: load, sort passes, emit
  rsst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_last  (s_axis_tlast),
    .s_ready (s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // record memory, min tracking, output register
  rsst_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_key    (s_axis_tdata[KEY_W-1:0]),
    .in_tag    (s_axis_tdata[PAYLOAD_W-1:KEY_W]),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .out_last  (m_axis_tlast),
    .out_ovf   (out_ovf),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata    = TDATA_W'({out_tag, out_key});
  assign m_axis_tuser[0] = out_ovf;

endmodule
